FILE: design/sequential_cpu_core_executor_core_assert.svh
// Assertion macros for the sequential executor core.
`ifndef SEQUENTIAL_CPU_CORE_EXECUTOR_CORE_ASSERT_SVH
`define SEQUENTIAL_CPU_CORE_EXECUTOR_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SCE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define SCE_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SCE_ASSERT(lbl, prop, msg)
`define SCE_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

FILE: design/sce_pkg.sv
// Shared types, codes and decode helpers for the sequential executor core.
package sce_pkg;

	localparam int SCE_MEM_BYTES = 4096;
	localparam int WORD_BYTES    = 4;
	localparam logic [2:0] ESP_REG = 3'd4;

	localparam logic [1:0] ST_RUN  = 2'd0;
	localparam logic [1:0] ST_HALT = 2'd1;
	localparam logic [1:0] ST_INS  = 2'd2;
	localparam logic [1:0] ST_ADR  = 2'd3;

	localparam logic [3:0] OP_HALT  = 4'h0;
	localparam logic [3:0] OP_NOP   = 4'h1;
	localparam logic [3:0] OP_CMOV  = 4'h2;
	localparam logic [3:0] OP_IRMOV = 4'h3;
	localparam logic [3:0] OP_RMMOV = 4'h4;
	localparam logic [3:0] OP_MRMOV = 4'h5;
	localparam logic [3:0] OP_OPL   = 4'h6;
	localparam logic [3:0] OP_JXX   = 4'h7;
	localparam logic [3:0] OP_CALL  = 4'h8;
	localparam logic [3:0] OP_RET   = 4'h9;
	localparam logic [3:0] OP_PUSH  = 4'hA;
	localparam logic [3:0] OP_POP   = 4'hB;

	localparam logic [1:0] ALU_ADD = 2'd0;
	localparam logic [1:0] ALU_SUB = 2'd1;
	localparam logic [1:0] ALU_AND = 2'd2;
	localparam logic [1:0] ALU_XOR = 2'd3;

	typedef struct packed {
		logic        cmd;
		logic [11:0] address;
		logic [7:0]  data;
		logic [2:0]  reg_index;
	} in_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [11:0] pc;
		logic [7:0]  opcode;
		logic [2:0]  cond_codes;
		logic [31:0] reg_value;
	} out_t;

	typedef struct packed {
		logic       ok;
		logic [2:0] len;
		logic       need_a;
		logic       need_b;
	} dec_t;

	function automatic dec_t decode(input logic [7:0] op);
		dec_t d;
		d = '{ok: 1'b0, len: 3'd1, need_a: 1'b0, need_b: 1'b0};
		case (op[7:4]) inside
			OP_HALT, OP_NOP, OP_RET: begin
				d.ok = op[3:0] == 4'd0;
			end
			OP_CMOV: begin
				d.len = 3'd2; d.ok = op[3:0] <= 4'd6; d.need_a = 1'b1; d.need_b = 1'b1;
			end
			OP_IRMOV: begin
				d.len = 3'd6; d.ok = op[3:0] == 4'd0; d.need_b = 1'b1;
			end
			OP_RMMOV, OP_MRMOV: begin
				d.len = 3'd6; d.ok = op[3:0] == 4'd0; d.need_a = 1'b1; d.need_b = 1'b1;
			end
			OP_OPL: begin
				d.len = 3'd2; d.ok = op[3:0] <= 4'd3; d.need_a = 1'b1; d.need_b = 1'b1;
			end
			OP_JXX: begin
				d.len = 3'd5; d.ok = op[3:0] <= 4'd6;
			end
			OP_CALL: begin
				d.len = 3'd5; d.ok = op[3:0] == 4'd0;
			end
			OP_PUSH, OP_POP: begin
				d.len = 3'd2; d.ok = op[3:0] == 4'd0; d.need_a = 1'b1;
			end
			default: d.ok = 1'b0;
		endcase
		return d;
	endfunction

	// cc: bit0 zero, bit1 sign, bit2 overflow
	function automatic logic cond_holds(input logic [2:0] cc, input logic [3:0] fn);
		logic lt;
		lt = cc[1] ^ cc[2];
		case (fn)
			4'd0: return 1'b1;
			4'd1: return lt | cc[0];
			4'd2: return lt;
			4'd3: return cc[0];
			4'd4: return ~cc[0];
			4'd5: return ~lt;
			default: return ~(lt | cc[0]);
		endcase
	endfunction

endpackage

FILE: design/sce_alu.sv
// Shared 32-bit add/sub/logic unit with condition flags.
module sce_alu
	import sce_pkg::*;
(
	input  logic [31:0] x,
	input  logic [31:0] y,
	input  logic [1:0]  op,
	output logic [31:0] res,
	output logic [2:0]  flags
);

	logic ovf;

	always_comb begin
		ovf = 1'b0;
		unique case (op)
			ALU_ADD: begin
				res = x + y;
				ovf = ~(x[31] ^ y[31]) & (res[31] ^ x[31]);
			end
			ALU_SUB: begin
				res = x - y;
				ovf = (x[31] ^ y[31]) & (res[31] ^ x[31]);
			end
			ALU_AND: res = x & y;
			default: res = x ^ y;
		endcase
		flags = {ovf, res[31], res == 32'd0};
	end

endmodule

FILE: design/sce_mem.sv
// Byte-wide program/data memory with a zeroing sweep after reset.
module sce_mem
	import sce_pkg::*;
#(
	parameter int MEM_BYTES = SCE_MEM_BYTES,
	localparam int AW = $clog2(MEM_BYTES)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          rd_ok,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata,
	output logic          ready
);

	logic [7:0]    mem [MEM_BYTES];
	logic [AW-1:0] clr_q;
	logic          clr_busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= '0;
			clr_busy_q <= 1'b1;
		end else if (clr_busy_q) begin
			clr_q <= clr_q + 1'b1;
			if (clr_q == AW'(MEM_BYTES - 1))
				clr_busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q)
			mem[clr_q] <= 8'd0;
		else if (we)
			mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (rd_ok)
			rdata <= mem[raddr];
		else
			rdata <= 8'd0;
	end

	assign ready = !clr_busy_q;

endmodule

FILE: design/sequential_cpu_core_executor_core.sv
// Top level: sequencer, register file and result register of the executor core.
//
// Request channel (req_valid/req_stall/req) takes one transaction at a time:
// a load (cmd 0) writes one memory byte, a step (cmd 1) runs one instruction.
// Every request yields exactly one response on rsp_valid/rsp_stall/rsp with
// status, pc, opcode, condition codes and the register named by reg_index.
// A load or a step of a stopped core goes from acceptance through S_FIN and S_OUT.
// A step walks fetch (one instruction byte per cycle), decode, three
// register-file reads, address, check, an optional one-word data access
// and writeback; popl adds a second writeback state, and mrmovl/rmmovl
// take the longest. Halt is found in decode, a fault at the first fetch
// goes straight to S_FIN. The byte-wide memory port and the single
// register-file read port set this sequence.
// A new request is taken in the cycle after the response register loads.
// After reset the memory is swept to zero byte by byte; req_stall
// stays high meanwhile. Registers, pc, flags and status reset to zero.
// The response sits in an output register; while rsp_stall is high it holds,
// and a finished request waits there before the next response can load.
module sequential_cpu_core_executor_core
	import sce_pkg::*;
#(
	parameter int MEM_BYTES = SCE_MEM_BYTES
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  in_t  req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output out_t rsp
);

	`include "sequential_cpu_core_executor_core_assert.svh"

	localparam int AW = $clog2(MEM_BYTES);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_FETCH = 4'd1;
	localparam logic [3:0] S_DEC   = 4'd2;
	localparam logic [3:0] S_RA1   = 4'd3;
	localparam logic [3:0] S_RA2   = 4'd4;
	localparam logic [3:0] S_RA3   = 4'd5;
	localparam logic [3:0] S_ADDR  = 4'd6;
	localparam logic [3:0] S_CHK   = 4'd7;
	localparam logic [3:0] S_DRD   = 4'd8;
	localparam logic [3:0] S_DWR   = 4'd9;
	localparam logic [3:0] S_WB    = 4'd10;
	localparam logic [3:0] S_WB2   = 4'd11;
	localparam logic [3:0] S_FIN   = 4'd12;
	localparam logic [3:0] S_OUT   = 4'd13;

	logic [3:0]    state_q, state_d;
	logic [AW-1:0] pc_q;
	logic [1:0]    status_q;
	logic [2:0]    cc_q;
	logic [7:0]    opc_q;
	logic [2:0]    ridx_q;
	logic [2:0]    cnt_q;
	logic [7:0]    ib_q [6];
	logic [7:0]    db_q [4];
	logic [31:0]   base_q, va_q, vb_q, addr_q, npc_q;
	logic [31:0]   rf_q [8];
	logic [31:0]   rf_rd_q;
	logic          rsp_valid_q;
	out_t          rsp_q;

	logic          mem_ready, mem_we, rd_ok;
	logic [7:0]    mem_rdata, mem_wdata;
	logic [31:0]   raddr32, waddr32;
	logic [2:0]    rf_raddr, rf_waddr;
	logic          rf_we;
	logic [31:0]   rf_wdata;
	logic [31:0]   alu_x, alu_y, alu_res;
	logic [1:0]    alu_op;
	logic [2:0]    alu_flags;

	logic          accept;
	dec_t          dec_f, dec;
	logic [3:0]    hi, fn, ra, rb;
	logic [31:0]   imm, pc32, seq_pc, word, wword;
	logic          is_data, is_read, is_write;

	assign accept    = req_valid && !req_stall;
	assign req_stall = !(state_q == S_IDLE && mem_ready);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign dec_f  = decode(mem_rdata);
	assign dec    = decode(ib_q[0]);
	assign hi     = ib_q[0][7:4];
	assign fn     = ib_q[0][3:0];
	assign ra     = ib_q[1][7:4];
	assign rb     = ib_q[1][3:0];
	assign imm    = (dec.len == 3'd6) ? {ib_q[5], ib_q[4], ib_q[3], ib_q[2]}
	                                  : {ib_q[4], ib_q[3], ib_q[2], ib_q[1]};
	assign pc32   = 32'(pc_q);
	assign seq_pc = pc32 + 32'(dec.len);
	assign word   = {mem_rdata, db_q[2], db_q[1], db_q[0]};
	assign wword  = (hi == OP_CALL) ? seq_pc : va_q;

	always_comb begin
		is_read  = hi == OP_MRMOV || hi == OP_RET || hi == OP_POP;
		is_write = hi == OP_RMMOV || hi == OP_CALL || hi == OP_PUSH;
		is_data  = is_read || is_write;
	end

	sce_mem #(.MEM_BYTES(MEM_BYTES)) u_mem (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (mem_we),
		.waddr (waddr32[AW-1:0]),
		.wdata (mem_wdata),
		.rd_ok (rd_ok),
		.raddr (raddr32[AW-1:0]),
		.rdata (mem_rdata),
		.ready (mem_ready)
	);

	sce_alu u_alu (
		.x    (alu_x),
		.y    (alu_y),
		.op   (alu_op),
		.res  (alu_res),
		.flags(alu_flags)
	);

	// memory port and ALU operand steering
	always_comb begin
		unique case (state_q)
			S_FETCH: raddr32 = pc32 + 32'(cnt_q) + 32'd1;
			S_CHK:   raddr32 = addr_q;
			S_DRD:   raddr32 = addr_q + 32'(cnt_q) + 32'd1;
			default: raddr32 = pc32;
		endcase
		rd_ok = raddr32 < 32'(MEM_BYTES);

		mem_we    = 1'b0;
		waddr32   = addr_q + 32'(cnt_q);
		mem_wdata = wword[8*cnt_q[1:0] +: 8];
		if (state_q == S_IDLE) begin
			waddr32   = 32'(req.address);
			mem_wdata = req.data;
			mem_we    = accept && !req.cmd && (32'(req.address) < 32'(MEM_BYTES));
		end else if (state_q == S_DWR) begin
			mem_we = 1'b1;
		end

		if (state_q == S_ADDR) begin
			alu_op = ALU_ADD;
			alu_x  = base_q;
			if (hi == OP_RMMOV || hi == OP_MRMOV)
				alu_y = imm;
			else if (hi == OP_CALL || hi == OP_PUSH)
				alu_y = -32'(WORD_BYTES);
			else
				alu_y = 32'd0;
		end else if (hi == OP_OPL) begin
			alu_op = fn[1:0];
			alu_x  = vb_q;
			alu_y  = va_q;
		end else begin
			alu_op = ALU_ADD;
			alu_x  = addr_q;
			alu_y  = 32'(WORD_BYTES);
		end
	end

	// register file write and read select
	always_comb begin
		rf_we    = 1'b0;
		rf_waddr = rb[2:0];
		rf_wdata = va_q;
		if (state_q == S_WB) begin
			case (hi) inside
				OP_CMOV: rf_we = cond_holds(cc_q, fn);
				OP_IRMOV: begin
					rf_we = 1'b1; rf_wdata = imm;
				end
				OP_MRMOV: begin
					rf_we = 1'b1; rf_waddr = ra[2:0]; rf_wdata = {db_q[3], db_q[2], db_q[1], db_q[0]};
				end
				OP_OPL: begin
					rf_we = 1'b1; rf_wdata = alu_res;
				end
				OP_CALL, OP_PUSH: begin
					rf_we = 1'b1; rf_waddr = ESP_REG; rf_wdata = addr_q;
				end
				OP_RET, OP_POP: begin
					rf_we = 1'b1; rf_waddr = ESP_REG; rf_wdata = alu_res;
				end
				default: rf_we = 1'b0;
			endcase
		end else if (state_q == S_WB2) begin
			rf_we    = 1'b1;
			rf_waddr = ra[2:0];
			rf_wdata = {db_q[3], db_q[2], db_q[1], db_q[0]};
		end

		unique case (state_q)
			S_DEC:   rf_raddr = (hi == OP_RMMOV || hi == OP_MRMOV) ? rb[2:0] : ESP_REG;
			S_RA1:   rf_raddr = ra[2:0];
			S_RA2:   rf_raddr = rb[2:0];
			default: rf_raddr = ridx_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++)
				rf_q[i] <= '0;
		end else if (rf_we) begin
			rf_q[rf_waddr] <= rf_wdata;
		end
	end

	always_ff @(posedge clk) begin
		rf_rd_q <= rf_q[rf_raddr];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pc_q        <= '0;
			status_q    <= ST_RUN;
			cc_q        <= '0;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			// S_OUT sets valid itself when it loads a new response
			if (rsp_valid_q && !rsp_stall && state_q != S_OUT)
				rsp_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						opc_q  <= 8'd0;
						ridx_q <= req.reg_index;
						cnt_q  <= '0;
						if (req.cmd && status_q == ST_RUN)
							state_q <= S_FETCH;
						else
							state_q <= S_FIN;
					end
				end
				S_FETCH: begin
					ib_q[cnt_q] <= mem_rdata;
					if (cnt_q == 3'd0) begin
						opc_q <= mem_rdata;
						if (!dec_f.ok) begin
							status_q <= ST_INS;
							state_q  <= S_FIN;
						end else if (pc32 + 32'(dec_f.len) > 32'(MEM_BYTES)) begin
							status_q <= ST_ADR;
							state_q  <= S_FIN;
						end else if (dec_f.len == 3'd1) begin
							state_q <= S_DEC;
						end else begin
							cnt_q <= 3'd1;
						end
					end else if (cnt_q + 3'd1 == dec.len) begin
						state_q <= S_DEC;
					end else begin
						cnt_q <= cnt_q + 3'd1;
					end
				end
				S_DEC: begin
					if ((dec.need_a && ra[3]) || (dec.need_b && rb[3])) begin
						status_q <= ST_INS;
						state_q  <= S_FIN;
					end else if (hi == OP_HALT) begin
						status_q <= ST_HALT;
						state_q  <= S_FIN;
					end else begin
						state_q <= S_RA1;
					end
				end
				S_RA1: begin
					base_q  <= rf_rd_q;
					state_q <= S_RA2;
				end
				S_RA2: begin
					va_q    <= rf_rd_q;
					state_q <= S_RA3;
				end
				S_RA3: begin
					vb_q    <= rf_rd_q;
					state_q <= S_ADDR;
				end
				S_ADDR: begin
					addr_q <= alu_res;
					if (hi == OP_CALL || (hi == OP_JXX && cond_holds(cc_q, fn)))
						npc_q <= imm;
					else
						npc_q <= seq_pc;
					state_q <= S_CHK;
				end
				S_CHK: begin
					cnt_q <= '0;
					if (is_data && addr_q > 32'(MEM_BYTES - WORD_BYTES)) begin
						status_q <= ST_ADR;
						state_q  <= S_FIN;
					end else if (is_read) begin
						state_q <= S_DRD;
					end else if (npc_q >= 32'(MEM_BYTES)) begin
						status_q <= ST_ADR;
						state_q  <= S_FIN;
					end else if (is_write) begin
						state_q <= S_DWR;
					end else begin
						state_q <= S_WB;
					end
				end
				S_DRD: begin
					db_q[cnt_q[1:0]] <= mem_rdata;
					if (cnt_q == 3'd3) begin
						if (hi == OP_RET) begin
							npc_q <= word;
							if (word >= 32'(MEM_BYTES)) begin
								status_q <= ST_ADR;
								state_q  <= S_FIN;
							end else begin
								state_q <= S_WB;
							end
						end else if (npc_q >= 32'(MEM_BYTES)) begin
							status_q <= ST_ADR;
							state_q  <= S_FIN;
						end else begin
							state_q <= S_WB;
						end
					end else begin
						cnt_q <= cnt_q + 3'd1;
					end
				end
				S_DWR: begin
					if (cnt_q == 3'd3)
						state_q <= S_WB;
					else
						cnt_q <= cnt_q + 3'd1;
				end
				S_WB: begin
					if (hi == OP_OPL)
						cc_q <= alu_flags;
					pc_q    <= npc_q[AW-1:0];
					state_q <= (hi == OP_POP) ? S_WB2 : S_FIN;
				end
				S_WB2: state_q <= S_FIN;
				S_FIN: state_q <= S_OUT;
				S_OUT: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// response payload
	always_ff @(posedge clk) begin
		if (state_q == S_OUT && (!rsp_valid_q || !rsp_stall)) begin
			rsp_q.status     <= status_q;
			rsp_q.pc         <= pc32[11:0];
			rsp_q.opcode     <= opc_q;
			rsp_q.cond_codes <= cc_q;
			rsp_q.reg_value  <= rf_rd_q;
		end
	end

	`SCE_ASSERT(a_status_sticky, status_q != ST_RUN |=> status_q != ST_RUN, "core restarted without reset")
	`SCE_ASSERT(a_pc_in_mem, 32'(pc_q) < 32'(MEM_BYTES), "pc outside memory")
	`SCE_ASSERT(a_no_accept_clear, !mem_ready |-> req_stall, "request taken during memory clear")
	`SCE_ASSERT(a_cnt_range, cnt_q <= 3'd5, "byte counter out of range")

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for the sequential Y86 executor core.
module testbench;
	import sce_pkg::*;

	localparam int MEMSZ      = SCE_MEM_BYTES;
	localparam int N_ITEMS    = 1550;
	localparam int QUIET_MAX  = 20000;
	localparam int HOLD_LEN   = 300;
	localparam int CODE_TOP   = 3880;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	in_t  req;
	logic rsp_valid;
	logic rsp_stall;
	out_t rsp;

	sequential_cpu_core_executor_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);

	always begin
		clk = 1'b0; #1;
		clk = 1'b1; #1;
	end

	// architectural mirror of the core
	logic [7:0]  m_mem [MEMSZ];
	logic [31:0] m_reg [8];
	logic [31:0] m_pc;
	logic [2:0]  m_cc;
	logic [1:0]  m_st;

	out_t exp_q [$];
	int   n_items;
	int   n_bad;
	int   snd_idle;
	int   rcv_idle;
	bit   hold_req;
	int   quiet;

	function automatic bit fits(logic [31:0] a, int n);
		return a <= 32'(MEMSZ - n);
	endfunction

	function automatic logic [31:0] word_at(logic [31:0] a);
		logic [31:0] v;
		logic [11:0] ix;
		v = '0;
		for (int k = 0; k < WORD_BYTES; k++) begin
			ix = a[11:0] + 12'(k);
			v |= 32'(m_mem[ix]) << (8 * k);
		end
		return v;
	endfunction

	function automatic void put_word(logic [31:0] a, logic [31:0] v);
		logic [11:0] ix;
		for (int k = 0; k < WORD_BYTES; k++) begin
			ix = a[11:0] + 12'(k);
			m_mem[ix] = v[8*k +: 8];
		end
	endfunction

	function automatic bit cc_true(logic [3:0] fn);
		bit z, lt;
		z  = m_cc[0];
		lt = m_cc[1] ^ m_cc[2];
		case (fn)
			4'd0: return 1'b1;
			4'd1: return lt | z;
			4'd2: return lt;
			4'd3: return z;
			4'd4: return !z;
			4'd5: return !lt;
			default: return !(lt | z);
		endcase
	endfunction

	function automatic void run_instr(output logic [7:0] opc);
		logic [31:0] pc, imm, npc, addr, a, b, t;
		logic [3:0]  hi, fn, ra, rb;
		logic [7:0]  op;
		logic        v;
		int          len;
		bit          ok, na, nb, dm;
		opc = '0; ra = '0; rb = '0; imm = '0; addr = '0;
		na = 0; nb = 0; dm = 0; v = 1'b0;
		pc = m_pc;
		if (!fits(pc, 1)) begin
			m_st = ST_ADR;
			return;
		end
		op  = m_mem[pc[11:0]];
		opc = op;
		hi  = op[7:4];
		fn  = op[3:0];
		case (hi)
			OP_HALT, OP_NOP, OP_RET: begin len = 1; ok = fn == 0; end
			OP_CMOV: begin len = 2; ok = fn <= 6; na = 1; nb = 1; end
			OP_IRMOV: begin len = 6; ok = fn == 0; nb = 1; end
			OP_RMMOV, OP_MRMOV: begin len = 6; ok = fn == 0; na = 1; nb = 1; end
			OP_OPL: begin len = 2; ok = fn <= 3; na = 1; nb = 1; end
			OP_JXX: begin len = 5; ok = fn <= 6; end
			OP_CALL: begin len = 5; ok = fn == 0; end
			OP_PUSH, OP_POP: begin len = 2; ok = fn == 0; na = 1; end
			default: begin len = 1; ok = 0; end
		endcase
		if (!ok) begin
			m_st = ST_INS;
			return;
		end
		if (!fits(pc, len)) begin
			m_st = ST_ADR;
			return;
		end
		if (len >= 2) begin
			ra = m_mem[pc[11:0] + 12'd1][7:4];
			rb = m_mem[pc[11:0] + 12'd1][3:0];
		end
		if ((na && ra > 7) || (nb && rb > 7)) begin
			m_st = ST_INS;
			return;
		end
		if (len == 6)
			imm = word_at(pc + 2);
		else if (len == 5)
			imm = word_at(pc + 1);
		if (hi == OP_HALT) begin
			m_st = ST_HALT;
			return;
		end
		npc = pc + 32'(len);
		case (hi)
			OP_RMMOV, OP_MRMOV: begin addr = m_reg[rb[2:0]] + imm; dm = 1; end
			OP_JXX: if (cc_true(fn)) npc = imm;
			OP_CALL: begin addr = m_reg[ESP_REG] - WORD_BYTES; dm = 1; npc = imm; end
			OP_RET, OP_POP: begin addr = m_reg[ESP_REG]; dm = 1; end
			OP_PUSH: begin addr = m_reg[ESP_REG] - WORD_BYTES; dm = 1; end
			default: ;
		endcase
		if (dm && !fits(addr, WORD_BYTES)) begin
			m_st = ST_ADR;
			return;
		end
		if (hi == OP_RET)
			npc = word_at(addr);
		if (npc >= MEMSZ) begin
			m_st = ST_ADR;
			return;
		end
		case (hi)
			OP_CMOV: if (cc_true(fn)) m_reg[rb[2:0]] = m_reg[ra[2:0]];
			OP_IRMOV: m_reg[rb[2:0]] = imm;
			OP_RMMOV: put_word(addr, m_reg[ra[2:0]]);
			OP_MRMOV: m_reg[ra[2:0]] = word_at(addr);
			OP_OPL: begin
				a = m_reg[ra[2:0]];
				b = m_reg[rb[2:0]];
				case (fn[1:0])
					ALU_ADD: begin t = b + a; v = ~(a[31] ^ b[31]) & (t[31] ^ b[31]); end
					ALU_SUB: begin t = b - a; v = (a[31] ^ b[31]) & (t[31] ^ b[31]); end
					ALU_AND: t = b & a;
					default: t = b ^ a;
				endcase
				m_reg[rb[2:0]] = t;
				m_cc = {v, t[31], t == 0};
			end
			OP_CALL: begin
				put_word(addr, pc + 32'(len));
				m_reg[ESP_REG] = addr;
			end
			OP_RET: m_reg[ESP_REG] = addr + WORD_BYTES;
			OP_PUSH: begin
				put_word(addr, m_reg[ra[2:0]]);
				m_reg[ESP_REG] = addr;
			end
			OP_POP: begin
				t = word_at(addr);
				m_reg[ESP_REG] = addr + WORD_BYTES;
				m_reg[ra[2:0]] = t;
			end
			default: ;
		endcase
		m_pc = npc;
	endfunction

	function automatic out_t predict(in_t it);
		out_t o;
		logic [7:0] opc;
		opc = '0;
		if (!it.cmd)
			m_mem[it.address] = it.data;
		else if (m_st == ST_RUN)
			run_instr(opc);
		o.status     = m_st;
		o.pc         = m_pc[11:0];
		o.opcode     = opc;
		o.cond_codes = m_cc;
		o.reg_value  = m_reg[it.reg_index];
		return o;
	endfunction

	task automatic send(in_t it, bit typed, out_t te);
		out_t pe;
		pe = predict(it);
		if (typed)
			pe = te;
		if ($urandom_range(99) < snd_idle) begin
			req_valid <= 1'b0;
			do @(negedge clk); while ($urandom_range(99) < snd_idle);
		end
		req       <= it;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		exp_q.push_back(pe);
		n_items++;
		@(negedge clk);
	endtask

	task automatic send_load(logic [11:0] a, logic [7:0] d);
		in_t it;
		it = '{cmd: 1'b0, address: a, data: d, reg_index: 3'($urandom_range(7))};
		send(it, 1'b0, '0);
	endtask

	task automatic send_step();
		in_t it;
		it = '{cmd: 1'b1, address: 12'($urandom), data: 8'($urandom),
			reg_index: 3'($urandom_range(7))};
		send(it, 1'b0, '0);
	endtask

	// writes an instruction at the current pc, then executes it
	task automatic run_code(logic [7:0] b [6], int len);
		logic [11:0] pc;
		if ($urandom_range(99) < 15)
			send_load(12'($urandom), 8'($urandom));
		pc = m_pc[11:0];
		for (int i = 0; i < len; i++)
			send_load(pc + 12'(i), b[i]);
		send_step();
	endtask

	function automatic logic [31:0] rand_imm();
		case ($urandom_range(9))
			0: return 32'h0000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h8000_0000;
			3: return 32'hffff_ffff;
			4: return 32'($urandom_range(0, 15));
			default: return $urandom;
		endcase
	endfunction

	// legal instruction that keeps the core running
	function automatic void gen_instr(output logic [7:0] b [6], output int len);
		logic [3:0]  ra, rb;
		logic [31:0] v, esp;
		int          k;
		for (int i = 0; i < 6; i++)
			b[i] = 8'($urandom);
		ra  = 4'($urandom_range(7));
		rb  = 4'($urandom_range(7));
		esp = m_reg[ESP_REG];
		k   = (m_pc > CODE_TOP) ? 6 : $urandom_range(10);
		if (k == 7 && !fits(esp - WORD_BYTES, WORD_BYTES)) k = 11;
		if (k == 8 && !(fits(esp, WORD_BYTES) && word_at(esp) <= CODE_TOP)) k = 11;
		if (k == 9 && !fits(esp - WORD_BYTES, WORD_BYTES)) k = 11;
		if (k == 10 && !fits(esp, WORD_BYTES)) k = 11;
		case (k)
			0: begin b[0] = {OP_NOP, 4'h0}; len = 1; end
			1: begin b[0] = {OP_CMOV, 4'($urandom_range(6))}; b[1] = {ra, rb}; len = 2; end
			2: begin
				b[0] = {OP_IRMOV, 4'h0};
				b[1] = {4'($urandom), rb};
				{b[5], b[4], b[3], b[2]} = rand_imm();
				len = 6;
			end
			3, 4: begin
				b[0] = {(k == 3) ? OP_RMMOV : OP_MRMOV, 4'h0};
				b[1] = {ra, rb};
				v = 32'($urandom_range(0, MEMSZ - WORD_BYTES)) - m_reg[rb[2:0]];
				{b[5], b[4], b[3], b[2]} = v;
				len = 6;
			end
			5: begin b[0] = {OP_OPL, 4'($urandom_range(3))}; b[1] = {ra, rb}; len = 2; end
			6, 7: begin
				b[0] = (k == 6) ? {OP_JXX, 4'($urandom_range(6))} : {OP_CALL, 4'h0};
				if (m_pc > CODE_TOP) b[0] = {OP_JXX, 4'h0};
				{b[4], b[3], b[2], b[1]} = 32'($urandom_range(0, CODE_TOP));
				len = 5;
			end
			8: begin b[0] = {OP_RET, 4'h0}; len = 1; end
			9: begin b[0] = {OP_PUSH, 4'h0}; b[1] = {ra, 4'($urandom)}; len = 2; end
			10: begin b[0] = {OP_POP, 4'h0}; b[1] = {ra, 4'($urandom)}; len = 2; end
			default: begin
				// stack pointer wandered off, put it back in range
				b[0] = {OP_IRMOV, 4'h0};
				b[1] = {4'hf, 1'b0, ESP_REG};
				{b[5], b[4], b[3], b[2]} = 32'($urandom_range(2048, MEMSZ) & ~3);
				len = 6;
			end
		endcase
	endfunction

	// instruction that stops the core, after a jump to the last byte in one case
	task automatic stop_core();
		logic [7:0] b [6];
		logic [3:0] r;
		for (int i = 0; i < 6; i++)
			b[i] = 8'($urandom);
		r = 4'($urandom_range(7));
		case ($urandom_range(5))
			0: b[0] = {OP_HALT, 4'h0};
			1: b[0] = {4'($urandom_range(12, 15)), 4'($urandom)};
			2: b[0] = {OP_OPL, 4'($urandom_range(4, 15))};
			3: begin b[0] = {OP_OPL, 4'h0}; b[1] = {4'($urandom_range(8, 15)), r}; end
			4: begin
				b[0] = {OP_MRMOV, 4'h0};
				b[1] = {r, r};
				{b[5], b[4], b[3], b[2]} = 32'($urandom_range(MEMSZ - 3, MEMSZ + 8))
					- m_reg[r[2:0]];
			end
			default: begin
				// jump to the last byte, then fetch an instruction that runs past it
				b[0] = {OP_JXX, 4'h0};
				{b[4], b[3], b[2], b[1]} = 32'(MEMSZ - 1);
				run_code(b, 5);
				b[0] = {OP_IRMOV, 4'h0};
			end
		endcase
		run_code(b, 6);
	endtask

	typedef struct {
		in_t  it;
		bit   typed;
		out_t res;
	} dir_row_t;

	dir_row_t dir_tab [$];

	function automatic void add_row(logic c, logic [11:0] a, logic [7:0] d,
			logic [2:0] r, bit t, out_t e);
		dir_row_t row;
		row.it    = '{cmd: c, address: a, data: d, reg_index: r};
		row.typed = t;
		row.res   = e;
		dir_tab.push_back(row);
	endfunction

	// receiver: random stall, or a long hold-off when asked
	initial begin
		rsp_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				rsp_stall <= 1'b1;
				repeat (HOLD_LEN) @(negedge clk);
				hold_req = 0;
			end else begin
				rsp_stall <= ($urandom_range(99) < rcv_idle);
			end
		end
	end

	always @(posedge clk) begin
		out_t e;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (exp_q.size() == 0) begin
				n_bad++;
				if (n_bad <= 10)
					$display("unexpected transaction: %h", rsp);
			end else begin
				e = exp_q.pop_front();
				if (rsp.status !== e.status || rsp.pc !== e.pc || rsp.opcode !== e.opcode
						|| rsp.cond_codes !== e.cond_codes || rsp.reg_value !== e.reg_value) begin
					n_bad++;
					if (n_bad <= 10)
						$display("mismatch: st %0d/%0d pc %h/%h op %h/%h cc %0d/%0d reg %h/%h",
							e.status, rsp.status, e.pc, rsp.pc, e.opcode, rsp.opcode,
							e.cond_codes, rsp.cond_codes, e.reg_value, rsp.reg_value);
				end
			end
		end
	end

	// watchdog on cycles without any accepted transaction
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_MAX) begin
			$display("sequential_cpu_core_executor_core test failed");
			$finish;
		end
	end

	initial begin
		logic [7:0] b [6];
		logic [7:0] prog [17];
		int         len;
		out_t       zero_res;
		out_t       e;

		arst_n    = 1'b0;
		req_valid = 1'b0;
		req       = '0;
		quiet     = 0;
		n_items   = 0;
		n_bad     = 0;
		hold_req  = 0;
		snd_idle  = 31;
		rcv_idle  = 76;
		for (int i = 0; i < MEMSZ; i++) m_mem[i] = '0;
		for (int i = 0; i < 8; i++) m_reg[i] = '0;
		m_pc = '0;
		m_cc = '0;
		m_st = ST_RUN;
		zero_res = '0;

		// loads after reset: everything reads back as zero
		add_row(1'b0, 12'h000, 8'h00, 3'd0, 1, zero_res);
		add_row(1'b0, 12'hfff, 8'hff, 3'd7, 1, zero_res);
		add_row(1'b0, 12'hfff, 8'h00, 3'd3, 1, zero_res);
		add_row(1'b0, 12'haaa, 8'h55, 3'd5, 1, zero_res);
		add_row(1'b0, 12'h555, 8'haa, 3'd2, 1, zero_res);
		// irmovl max positive to eax, irmovl 1 to ecx, addl ecx,eax overflows
		prog = '{8'h30, 8'hf0, 8'hff, 8'hff, 8'hff, 8'h7f,
			8'h30, 8'hf1, 8'h01, 8'h00, 8'h00, 8'h00, 8'h60, 8'h10,
			8'h00, 8'h00, 8'h00};
		for (int i = 0; i < 6; i++) add_row(1'b0, 12'(i), prog[i], 3'd0, 1, zero_res);
		e = '{status: ST_RUN, pc: 12'd6, opcode: 8'h30, cond_codes: 3'd0,
			reg_value: 32'h7fff_ffff};
		add_row(1'b1, 12'h0, 8'h0, 3'd0, 1, e);
		for (int i = 6; i < 12; i++) add_row(1'b0, 12'(i), prog[i], 3'd1, 0, zero_res);
		add_row(1'b1, 12'hfff, 8'hff, 3'd1, 0, zero_res);
		for (int i = 12; i < 14; i++) add_row(1'b0, 12'(i), prog[i], 3'd0, 0, zero_res);
		e = '{status: ST_RUN, pc: 12'd14, opcode: 8'h60, cond_codes: 3'b110,
			reg_value: 32'h8000_0000};
		add_row(1'b1, 12'h0, 8'h0, 3'd0, 1, e);

		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_tab[i])
			send(dir_tab[i].it, dir_tab[i].typed, dir_tab[i].res);

		while (n_items < N_ITEMS) begin
			if (n_items > N_ITEMS / 3 && snd_idle == 31) begin
				snd_idle = 76;
				rcv_idle = 31;
			end
			if (n_items > 2 * N_ITEMS / 3 && snd_idle == 76) begin
				snd_idle = 0;
				rcv_idle = 0;
				hold_req = 1;
			end
			gen_instr(b, len);
			run_code(b, len);
		end

		// stop the core, then poke it while stopped
		stop_core();
		repeat (30) begin
			if ($urandom_range(1))
				send_step();
			else
				send_load(12'($urandom), 8'($urandom));
		end

		req_valid <= 1'b0;
		while (exp_q.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (n_bad == 0)
			$display("sequential_cpu_core_executor_core test passed");
		else
			$display("sequential_cpu_core_executor_core test failed");
		$finish;
	end

endmodule

FILE: files.f
+incdir+design
design/sce_pkg.sv
design/sce_alu.sv
design/sce_mem.sv
design/sequential_cpu_core_executor_core.sv
verif/testbench.sv
